[design/xcfp_pkg.sv]
// Shared types, character codes and command tables for the XOR checksum frame parser.
// Used by xcfp_core and xor_checksum_frame_parser; has no dependencies.
package xcfp_pkg;

  localparam int MAX_FRAME_LEN_DEF = 256;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_A_LESS_TEN = 8'h37;

  localparam int PREFIX_LEN = 5;
  localparam int NUM_CMDS   = 4;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_PSIGN = 3'd1;
  localparam logic [2:0] CMD_PFLSH = 3'd2;
  localparam logic [2:0] CMD_PBLFL = 3'd3;
  localparam logic [2:0] CMD_PEEPR = 3'd4;

  localparam logic [2:0] CMD_CODES [NUM_CMDS] = '{CMD_PSIGN, CMD_PFLSH, CMD_PBLFL, CMD_PEEPR};

  localparam logic [7:0] CMD_NAMES [NUM_CMDS][PREFIX_LEN] = '{
    '{8'h50, 8'h53, 8'h49, 8'h47, 8'h4E},
    '{8'h50, 8'h46, 8'h4C, 8'h53, 8'h48},
    '{8'h50, 8'h42, 8'h4C, 8'h46, 8'h4C},
    '{8'h50, 8'h45, 8'h45, 8'h50, 8'h52}
  };

  typedef struct packed {
    logic       checksum_ok;
    logic [2:0] command;
    logic       overflow;
  } verdict_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + {4'h0, nib};
    end else begin
      return CHAR_A_LESS_TEN + {4'h0, nib};
    end
  endfunction

endpackage

[design/xcfp_core.sv]
// Frame state and combinational verdict logic of the XOR checksum frame parser.
// Depends on xcfp_pkg.
module xcfp_core
  import xcfp_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
  localparam int CW = $clog2(MAX_FRAME_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    rx_byte,
  output logic          verdict_valid,
  output verdict_t      verdict,
  output logic [CW-1:0] verdict_length
);

  logic          in_frame;
  logic [7:0]    running_xor;
  logic          seen_star;
  logic [1:0]    hex_count;
  logic [7:0]    hex_chars [2];
  logic [7:0]    prefix_chars [PREFIX_LEN];
  logic [CW-1:0] char_count;
  logic          overflow_flag;

  logic          is_dollar;
  logic          is_lf;
  logic          is_star;
  logic          digits_ok;
  logic [2:0]    cmd_found;
  logic          body_byte;
  logic          short_body;

  assign is_dollar  = rx_byte == CHAR_DOLLAR;
  assign is_lf      = rx_byte == CHAR_LF;
  assign is_star    = rx_byte == CHAR_STAR;
  assign short_body = char_count < CW'(PREFIX_LEN);
  assign body_byte  = fire && !is_dollar && in_frame && !is_lf && !seen_star && !is_star;

  assign digits_ok = (hex_count == 2'd2) &&
                     (hex_chars[0] == hex_char(running_xor[7:4])) &&
                     (hex_chars[1] == hex_char(running_xor[3:0]));

  always_comb begin
    logic match;
    cmd_found = CMD_NONE;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      match = 1'b1;
      for (int j = 0; j < PREFIX_LEN; j++) begin
        if (prefix_chars[j] != CMD_NAMES[k][j]) begin
          match = 1'b0;
        end
      end
      if (match) begin
        cmd_found = CMD_CODES[k];
      end
    end
    if (short_body) begin
      cmd_found = CMD_NONE;
    end
  end

  assign verdict_valid       = fire && !is_dollar && in_frame && is_lf && seen_star;
  assign verdict.checksum_ok = digits_ok;
  assign verdict.command     = digits_ok ? cmd_found : CMD_NONE;
  assign verdict.overflow    = overflow_flag;
  assign verdict_length      = char_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      running_xor   <= '0;
      seen_star     <= 1'b0;
      hex_count     <= '0;
      hex_chars[0]  <= '0;
      hex_chars[1]  <= '0;
      char_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (fire) begin
      priority if (is_dollar) begin
        in_frame      <= 1'b1;
        running_xor   <= '0;
        seen_star     <= 1'b0;
        hex_count     <= '0;
        hex_chars[0]  <= '0;
        hex_chars[1]  <= '0;
        char_count    <= '0;
        overflow_flag <= 1'b0;
      end else if (!in_frame) begin
      end else if (is_lf) begin
        in_frame <= 1'b0;
      end else if (seen_star) begin
        if (hex_count < 2'd2) begin
          hex_chars[hex_count[0]] <= rx_byte;
          hex_count               <= hex_count + 2'd1;
        end
      end else if (is_star) begin
        seen_star <= 1'b1;
      end else begin
        running_xor <= running_xor ^ rx_byte;
        if (char_count < CW'(MAX_FRAME_LEN)) begin
          char_count <= char_count + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
    end
  end

  // prefix store holds no reset; read only once five body bytes have landed
  always_ff @(posedge clk) begin
    if (body_byte && short_body) begin
      prefix_chars[char_count[2:0]] <= rx_byte;
    end
  end

endmodule

[design/xor_checksum_frame_parser.sv]
// XOR checksum frame parser, top level: input handshake, parser core, output register and skid.
// Depends on xcfp_pkg and xcfp_core.
//
// Takes one received byte per transfer and gives one verdict per "$<body>*<hh>\n" frame:
// checksum_ok when the two characters after '*' are the uppercase hex form of the XOR of the
// body, the command found in the first five body bytes (0 unless the checksum is good), the
// body length saturated at MAX_FRAME_LEN, and an overflow flag. A byte can be accepted every
// cycle while in_ready is high. The verdict of a frame is registered from its ending '\n' into
// the output register, or into the skid stage when the output is stalled. A frame without '*'
// ends with no verdict. An output register plus a one-entry skid stage keep input flowing while
// a verdict waits; in_ready drops only when both hold verdicts.
module xor_checksum_frame_parser
  import xcfp_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
  localparam int CW = $clog2(MAX_FRAME_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          checksum_ok,
  output logic [2:0]    command,
  output logic [CW-1:0] body_length,
  output logic          overflow
);

  logic          fire;
  logic          produce;
  verdict_t      new_verdict;
  logic [CW-1:0] new_length;

  verdict_t      out_verdict;
  logic [CW-1:0] out_length;
  logic          skid_valid;
  verdict_t      skid_verdict;
  logic [CW-1:0] skid_length;

  assign in_ready = !skid_valid;
  assign fire     = in_valid && in_ready;

  xcfp_core #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .rx_byte       (rx_byte),
    .verdict_valid (produce),
    .verdict       (new_verdict),
    .verdict_length(new_length)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (produce) begin
        skid_valid   <= 1'b1;
        skid_verdict <= new_verdict;
        skid_length  <= new_length;
      end
    end else if (skid_valid) begin
      out_valid   <= 1'b1;
      out_verdict <= skid_verdict;
      out_length  <= skid_length;
      skid_valid  <= 1'b0;
    end else begin
      out_valid   <= produce;
      out_verdict <= new_verdict;
      out_length  <= new_length;
    end
  end

  assign checksum_ok = out_verdict.checksum_ok;
  assign command     = out_verdict.command;
  assign overflow    = out_verdict.overflow;
  assign body_length = out_length;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a verdict while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid verdict did not advance after output transfer");

  a_bad_sum_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_ok |-> command == CMD_NONE)
    else $error("command reported for a frame with a bad checksum");

  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> body_length == CW'(MAX_FRAME_LEN))
    else $error("overflow verdict without saturated body length");

  a_stall_capture: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && produce |=> skid_valid)
    else $error("verdict dropped while the output was stalled");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for xor_checksum_frame_parser: sends framed byte streams and checks
// every verdict against a scoreboard that predicts it. Depends on xcfp_pkg and the design.
module testbench
  import xcfp_pkg::*;
();

  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 500000;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {TAIL_GOOD, TAIL_BAD, TAIL_LOWER, TAIL_ONE_DIGIT, TAIL_NO_DIGITS, TAIL_TRAILING,
                TAIL_NO_STAR} tail_e;
  typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_e;

  class frame_scoreboard;
    localparam int BODY_LIMIT = xcfp_pkg::MAX_FRAME_LEN_DEF;

    typedef struct packed {
      logic       ok;
      logic [2:0] cmd;
      logic [8:0] len;
      logic       ovf;
    } frame_result_t;

    bit          in_frame = 1'b0;
    bit          seen_star = 1'b0;
    logic [7:0]  acc_xor = 8'h00;
    int unsigned digit_cnt = 0;
    logic [7:0]  digits[2] = '{8'h00, 8'h00};
    logic [7:0]  head[5] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    int unsigned body_cnt = 0;
    bit          too_long = 1'b0;
    frame_result_t results_due[$];
    int unsigned mismatches = 0;

    static function logic [7:0] hex_char(logic [3:0] nib, bit lower_case);
      logic [127:0] upper_tab;
      logic [127:0] lower_tab;
      upper_tab = "0123456789ABCDEF";
      lower_tab = "0123456789abcdef";
      return lower_case ? lower_tab[8*(15-nib) +: 8] : upper_tab[8*(15-nib) +: 8];
    endfunction

    function logic [2:0] lookup_command();
      logic [39:0] word;
      word = {head[0], head[1], head[2], head[3], head[4]};
      if (body_cnt < 5) return xcfp_pkg::CMD_NONE;
      case (word)
        "PSIGN":  return xcfp_pkg::CMD_PSIGN;
        "PFLSH":  return xcfp_pkg::CMD_PFLSH;
        "PBLFL":  return xcfp_pkg::CMD_PBLFL;
        "PEEPR":  return xcfp_pkg::CMD_PEEPR;
        default:  return xcfp_pkg::CMD_NONE;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      frame_result_t v;
      if (b == xcfp_pkg::CHAR_DOLLAR) begin
        in_frame = 1'b1;
        seen_star = 1'b0;
        acc_xor = 8'h00;
        digit_cnt = 0;
        digits = '{8'h00, 8'h00};
        body_cnt = 0;
        too_long = 1'b0;
        return;
      end
      if (!in_frame) return;
      if (b == xcfp_pkg::CHAR_LF) begin
        in_frame = 1'b0;
        if (!seen_star) return;
        v.ok = digit_cnt == 2 && digits[0] == hex_char(acc_xor[7:4], 1'b0) &&
               digits[1] == hex_char(acc_xor[3:0], 1'b0);
        v.cmd = v.ok ? lookup_command() : xcfp_pkg::CMD_NONE;
        v.len = 9'(body_cnt);
        v.ovf = too_long;
        results_due.push_back(v);
        return;
      end
      if (seen_star) begin
        if (digit_cnt < 2) begin
          digits[digit_cnt] = b;
          digit_cnt++;
        end
        return;
      end
      if (b == xcfp_pkg::CHAR_STAR) begin
        seen_star = 1'b1;
        return;
      end
      acc_xor ^= b;
      if (body_cnt < 5) head[body_cnt] = b;
      if (body_cnt < BODY_LIMIT) body_cnt++;
      else too_long = 1'b1;
    endfunction

    function void check_verdict(logic ok, logic [2:0] cmd, logic [8:0] len, logic ovf);
      frame_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict: ok=%0d command=%0d length=%0d overflow=%0d",
                   ok, cmd, len, ovf);
        return;
      end
      want = results_due.pop_front();
      if (want.ok !== ok || want.cmd !== cmd || want.len !== len || want.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("verdict mismatch: expected ok=%0d command=%0d length=%0d overflow=%0d",
                   want.ok, want.cmd, want.len, want.ovf);
          $display("                  got      ok=%0d command=%0d length=%0d overflow=%0d",
                   ok, cmd, len, ovf);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       checksum_ok;
  logic [2:0] command;
  logic [8:0] body_length;
  logic       overflow;

  frame_scoreboard sb;
  byte_q_t         tx_q;
  int unsigned     accepted_bytes = 0;
  int unsigned     burst_left = 0;
  bit              gaps_on = 1'b1;
  bit              hold_req = 1'b0;
  int unsigned     cycle_count = 0;

  xor_checksum_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .checksum_ok(checksum_ok),
    .command(command),
    .body_length(body_length),
    .overflow(overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] body_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_DOLLAR || b == CHAR_STAR || b == CHAR_LF);
    return b;
  endfunction

  function automatic byte_q_t str_body(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic byte_q_t rand_body(int unsigned len);
    byte_q_t     q;
    logic [39:0] name;
    bit          named;
    named = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 3))
      0:       name = "PSIGN";
      1:       name = "PFLSH";
      2:       name = "PBLFL";
      default: name = "PEEPR";
    endcase
    if ($urandom_range(0, 4) == 0) name[8*$urandom_range(0, 4) +: 8] = body_char();
    for (int k = 0; k < len; k++) q.push_back((named && k < 5) ? name[8*(4-k) +: 8] : body_char());
    return q;
  endfunction

  function automatic void add_frame(byte_q_t body, tail_e tail);
    logic [7:0] sum;
    logic [7:0] shown;
    bit         lower_case;
    sum = 8'h00;
    lower_case = tail == TAIL_LOWER;
    tx_q.push_back(CHAR_DOLLAR);
    foreach (body[i]) begin
      sum ^= body[i];
      tx_q.push_back(body[i]);
    end
    shown = (tail == TAIL_BAD) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    if (tail != TAIL_NO_STAR) tx_q.push_back(CHAR_STAR);
    case (tail)
      TAIL_GOOD, TAIL_BAD, TAIL_LOWER, TAIL_TRAILING: begin
        tx_q.push_back(frame_scoreboard::hex_char(shown[7:4], lower_case));
        tx_q.push_back(frame_scoreboard::hex_char(shown[3:0], lower_case));
      end
      TAIL_ONE_DIGIT: begin
        tx_q.push_back(frame_scoreboard::hex_char(shown[7:4], 1'b0));
      end
      default: ;
    endcase
    if (tail == TAIL_TRAILING) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0:       tx_q.push_back(CHAR_STAR);
          1:       tx_q.push_back(8'h0D);
          default: tx_q.push_back(body_char());
        endcase
      end
    end
    tx_q.push_back(CHAR_LF);
  endfunction

  // open a frame and leave it unterminated so that the next '$' restarts it
  function automatic void add_fragment();
    tx_q.push_back(CHAR_DOLLAR);
    repeat ($urandom_range(0, 6)) tx_q.push_back(body_char());
    if ($urandom_range(0, 1) == 1) begin
      tx_q.push_back(CHAR_STAR);
      repeat ($urandom_range(0, 2)) tx_q.push_back(body_char());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    accepted_bytes++;
    burst_left--;
  endtask

  task automatic flush_tx();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // receiver: random ready pattern per window, or one long hold on request
  initial begin
    rx_mode_e    mode;
    int unsigned window;
    mode = RX_OPEN;
    window = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (window == 0) begin
          window = $urandom_range(16, 96);
          mode = rx_mode_e'($urandom_range(0, 2));
        end
        window--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && out_ready)
      sb.check_verdict(checksum_ok, command, body_length, overflow);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    tail_e       tail;
    sb = new;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_q.push_back(CHAR_STAR);
    tx_q.push_back(CHAR_LF);
    tx_q.push_back(8'h00);
    tx_q.push_back(8'hFF);
    add_frame(str_body("PSIGN"), TAIL_GOOD);
    add_frame(str_body("PFLSH,12"), TAIL_GOOD);
    add_frame(str_body("PBLFL"), TAIL_GOOD);
    add_frame(str_body("PEEPR~"), TAIL_GOOD);
    add_frame(str_body("PSIGN"), TAIL_BAD);
    add_frame(str_body("PEEPR:Z"), TAIL_LOWER);
    add_frame(str_body("PSIG"), TAIL_GOOD);
    add_frame(str_body(""), TAIL_GOOD);
    add_frame(str_body("PFLSH"), TAIL_ONE_DIGIT);
    add_frame(str_body("PFLSH"), TAIL_NO_DIGITS);
    add_frame(str_body("PBLFL"), TAIL_TRAILING);
    add_frame(str_body("PSIGN"), TAIL_NO_STAR);
    tx_q.push_back(CHAR_DOLLAR);
    tx_q.push_back("P");
    add_frame(str_body("PSIGN"), TAIL_GOOD);
    tx_q.push_back(CHAR_DOLLAR);
    tx_q.push_back("P");
    tx_q.push_back(CHAR_STAR);
    add_frame(str_body("PEEPR"), TAIL_GOOD);
    add_frame('{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01}, TAIL_GOOD);
    add_frame(rand_body(256), TAIL_GOOD);
    add_frame(rand_body(257), TAIL_GOOD);
    add_frame(rand_body(300), TAIL_BAD);
    flush_tx();

    // stall the output long enough that both verdict slots fill and input backs up
    hold_req = 1'b1;
    repeat (12) add_frame(rand_body($urandom_range(0, 6)), TAIL_GOOD);
    flush_tx();

    target = accepted_bytes + RANDOM_ITEMS;
    while (accepted_bytes < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(0, 12);
      else if (pick < 98) len = $urandom_range(13, 48);
      else len = $urandom_range(250, 270);
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0) add_fragment();
      pick = $urandom_range(0, 99);
      if (pick < 55) tail = TAIL_GOOD;
      else if (pick < 65) tail = TAIL_BAD;
      else if (pick < 73) tail = TAIL_LOWER;
      else if (pick < 78) tail = TAIL_ONE_DIGIT;
      else if (pick < 83) tail = TAIL_NO_DIGITS;
      else if (pick < 91) tail = TAIL_TRAILING;
      else tail = TAIL_NO_STAR;
      add_frame(rand_body(len), tail);
      flush_tx();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/xcfp_pkg.sv
design/xcfp_core.sv
design/xor_checksum_frame_parser.sv
dv/testbench.sv
